// File: hw/rtl/i2cdws_pkg.sv
// ----------------------------------------------------------------------------
// I2C display write sequencer package
// Shared item types, command codes, bus action codes and reset constants.
// ----------------------------------------------------------------------------
package i2cdws_pkg;

	// Command codes carried in the cmd field of an input item.
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_EVENT   = 1'b1;

	// Address byte with the write bit, used until software writes another.
	localparam logic [7:0] DEV_ADDR_RESET = 8'h78;

	// Bus action requested from the bit shifter.
	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_START_SEND = 3'd1,
		ACT_SEND       = 3'd2,
		ACT_SAMPLE     = 3'd3,
		ACT_STOP       = 3'd4,
		ACT_RELEASE    = 3'd5,
		ACT_START_STOP = 3'd6
	} action_t;

	// One input item: a transfer request or a shifter-done event.
	typedef struct packed {
		logic        cmd;
		logic [7:0]  ctrl_byte;
		logic [15:0] data_len;
		logic        repeat_payload;
		logic [7:0]  payload_byte;
		logic        nack_bit;
	} in_item_t;

	// One result item: the bus action and its side information.
	typedef struct packed {
		action_t     action;
		logic [7:0]  tx_byte;
		logic        advance_payload;
		logic        request_rejected;
		logic        transfer_done;
	} out_item_t;

endpackage

// File: hw/rtl/i2cdws_fsm.sv
// ----------------------------------------------------------------------------
// I2C display write sequencer state machine
// Holds the bus and byte phases and the transfer context, and turns one
// item per enabled cycle into one registered bus action.
// ----------------------------------------------------------------------------
module i2cdws_fsm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  i2cdws_pkg::in_item_t   item,
	input  logic [7:0]             dev_addr,
	output i2cdws_pkg::out_item_t  result
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SAMPLE = 2'd1,
		PH_CHECK  = 2'd2,
		PH_STOP   = 2'd3
	} bus_phase_t;

	typedef enum logic [1:0] {
		BY_ADDR = 2'd0,
		BY_CTRL = 2'd1,
		BY_DATA = 2'd2
	} byte_phase_t;

	bus_phase_t            bus_q, bus_nxt;
	byte_phase_t           byte_q, byte_nxt;
	logic [7:0]            ctrl_q, ctrl_nxt;
	logic [15:0]           remain_q, remain_nxt;
	logic                  repeat_q, repeat_nxt;
	i2cdws_pkg::out_item_t result_q, result_nxt;

	// Next state and bus action for the item presented this cycle.
	always_comb begin
		bus_nxt    = bus_q;
		byte_nxt   = byte_q;
		ctrl_nxt   = ctrl_q;
		remain_nxt = remain_q;
		repeat_nxt = repeat_q;
		result_nxt = '0;
		result_nxt.action = i2cdws_pkg::ACT_NONE;

		if (item.cmd == i2cdws_pkg::CMD_REQUEST) begin
			if (bus_q != PH_IDLE) begin
				// A request during a transfer is dropped and flagged.
				result_nxt.request_rejected = 1'b1;
			end else begin
				ctrl_nxt   = item.ctrl_byte;
				remain_nxt = item.data_len;
				repeat_nxt = item.repeat_payload;
				byte_nxt   = BY_ADDR;
				if (item.data_len == 16'd0) begin
					// An empty transfer is only a start and a stop.
					result_nxt.action = i2cdws_pkg::ACT_START_STOP;
					bus_nxt = PH_STOP;
				end else begin
					result_nxt.action  = i2cdws_pkg::ACT_START_SEND;
					result_nxt.tx_byte = dev_addr;
					byte_nxt = BY_CTRL;
					bus_nxt  = PH_SAMPLE;
				end
			end
		end else begin
			unique case (bus_q)
				PH_SAMPLE: begin
					result_nxt.action = i2cdws_pkg::ACT_SAMPLE;
					bus_nxt = PH_CHECK;
				end
				PH_CHECK: begin
					if (item.nack_bit || remain_q == 16'd0) begin
						result_nxt.action = i2cdws_pkg::ACT_STOP;
						bus_nxt = PH_STOP;
					end else begin
						result_nxt.action = i2cdws_pkg::ACT_SEND;
						unique case (byte_q)
							BY_ADDR: begin
								result_nxt.tx_byte = dev_addr;
								byte_nxt = BY_CTRL;
							end
							BY_CTRL: begin
								result_nxt.tx_byte = ctrl_q;
								byte_nxt = BY_DATA;
							end
							default: begin
								// Payload byte; the source steps unless repeating.
								result_nxt.tx_byte = item.payload_byte;
								result_nxt.advance_payload = ~repeat_q;
								remain_nxt = remain_q - 16'd1;
							end
						endcase
						bus_nxt = PH_SAMPLE;
					end
				end
				PH_STOP: begin
					result_nxt.action = i2cdws_pkg::ACT_RELEASE;
					result_nxt.transfer_done = 1'b1;
					bus_nxt = PH_IDLE;
				end
				default: begin
					// Events while idle produce no bus action.
					result_nxt.action = i2cdws_pkg::ACT_NONE;
				end
			endcase
		end
	end

	// State and result register, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q    <= PH_IDLE;
			byte_q   <= BY_ADDR;
			ctrl_q   <= 8'd0;
			remain_q <= 16'd0;
			repeat_q <= 1'b0;
			result_q <= '0;
		end else if (fire) begin
			bus_q    <= bus_nxt;
			byte_q   <= byte_nxt;
			ctrl_q   <= ctrl_nxt;
			remain_q <= remain_nxt;
			repeat_q <= repeat_nxt;
			result_q <= result_nxt;
		end
	end

	assign result = result_q;

endmodule

// File: hw/rtl/i2c_display_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C display write sequencer core
// Write-only I2C master step sequencer: one bus action per input item.
// ----------------------------------------------------------------------------
// Every accepted item (a transfer request or a shifter-done event) yields
// exactly one result item. The block takes one item per clock cycle while
// req_stall is low; each item is held in the input register while the
// sequencer step computes the result register that drives the output.
// While a result is stalled the whole pipeline holds and req_stall is raised.
// The device address register may be written through the cfg channel, which
// is always ready; write it only while no transfer is pending.
module i2c_display_write_sequencer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	// Item input channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  i2cdws_pkg::in_item_t  req_data,
	// Result output channel
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output i2cdws_pkg::out_item_t rsp_data,
	// Device address register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	logic                 advance;
	logic                 fire;
	logic                 valid_s1;
	i2cdws_pkg::in_item_t item_s1;
	logic                 rsp_valid_q;
	logic [7:0]           dev_addr_q;

	// The pipeline moves whenever the result register is free or being taken.
	assign advance   = ~(rsp_valid_q & rsp_stall);
	assign req_stall = ~advance;
	assign fire      = advance & valid_s1;
	assign cfg_ready = 1'b1;

	// Input register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= req_valid;
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			item_s1 <= req_data;
		end
	end

	// Device address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2cdws_pkg::DEV_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	// Sequencer step with its result register.
	i2cdws_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.dev_addr (dev_addr_q),
		.result   (rsp_data)
	);

	assign rsp_valid = rsp_valid_q;

	// A result appears in the cycle after its item leaves the input register.
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (rsp_valid == $past(valid_s1)))
		else $error("result valid does not track the input register");

	// Only a release reports the end of a transfer.
	a_done_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.transfer_done ==
			(rsp_data.action == i2cdws_pkg::ACT_RELEASE)))
		else $error("transfer_done disagrees with the bus action");

	// A rejected request never comes with a bus action or a payload step.
	a_reject_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.request_rejected) |->
			(rsp_data.action == i2cdws_pkg::ACT_NONE && !rsp_data.advance_payload))
		else $error("rejected request produced a bus action");

	// The source is only told to step on a plain byte send.
	a_advance_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.advance_payload) |->
			(rsp_data.action == i2cdws_pkg::ACT_SEND))
		else $error("payload advance outside a byte send");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C display write sequencer testbench
// Drives transfer requests and shifter-done events into the sequencer core,
// predicts every bus action in a scoreboard and compares each result field by
// field. A short directed part covers the special cases. Random transfers with
// occasional NACKs, stray events and rejected requests follow, under three idle
// patterns and several device address settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 650;
	localparam int MAX_PRINTED = 50;

	// Bus and byte phases as tracked by the scoreboard.
	typedef enum logic [1:0] {
		BUS_IDLE   = 2'd0,
		BUS_SAMPLE = 2'd1,
		BUS_CHECK  = 2'd2,
		BUS_STOP   = 2'd3
	} bus_phase_t;

	typedef enum logic [1:0] {
		BYTE_ADDR = 2'd0,
		BYTE_CTRL = 2'd1,
		BYTE_DATA = 2'd2
	} byte_phase_t;

	// Predicts the bus action for each accepted item and checks the results.
	class bus_action_scoreboard_t;
		bus_phase_t  bus_phase;
		byte_phase_t byte_phase;
		logic [7:0]  dev_addr;
		logic [7:0]  held_ctrl;
		logic [15:0] bytes_left;
		logic        repeat_mode;
		i2cdws_pkg::out_item_t expected_actions[$];
		int unsigned fail_count;

		function new();
			bus_phase = BUS_IDLE;
			byte_phase = BYTE_ADDR;
			dev_addr = i2cdws_pkg::DEV_ADDR_RESET;
			held_ctrl = '0;
			bytes_left = '0;
			repeat_mode = 1'b0;
			fail_count = 0;
		endfunction

		function void set_address(logic [7:0] addr);
			dev_addr = addr;
		endfunction

		function int pending();
			return expected_actions.size();
		endfunction

		function bit is_idle();
			return bus_phase == BUS_IDLE;
		endfunction

		// Steps the sequencer state for one accepted item and queues its result.
		function i2cdws_pkg::action_t note_accepted_item(i2cdws_pkg::in_item_t item);
			i2cdws_pkg::out_item_t res;
			res = '0;
			res.action = i2cdws_pkg::ACT_NONE;
			if (item.cmd == i2cdws_pkg::CMD_REQUEST) begin
				if (bus_phase != BUS_IDLE) begin
					res.request_rejected = 1'b1;
				end else begin
					held_ctrl = item.ctrl_byte;
					bytes_left = item.data_len;
					repeat_mode = item.repeat_payload;
					byte_phase = BYTE_ADDR;
					if (item.data_len == 16'd0) begin
						res.action = i2cdws_pkg::ACT_START_STOP;
						bus_phase = BUS_STOP;
					end else begin
						res.action = i2cdws_pkg::ACT_START_SEND;
						res.tx_byte = dev_addr;
						byte_phase = BYTE_CTRL;
						bus_phase = BUS_SAMPLE;
					end
				end
			end else begin
				case (bus_phase)
					BUS_SAMPLE: begin
						res.action = i2cdws_pkg::ACT_SAMPLE;
						bus_phase = BUS_CHECK;
					end
					BUS_CHECK: begin
						if (item.nack_bit || bytes_left == 16'd0) begin
							res.action = i2cdws_pkg::ACT_STOP;
							bus_phase = BUS_STOP;
						end else begin
							res.action = i2cdws_pkg::ACT_SEND;
							case (byte_phase)
								BYTE_ADDR: begin
									res.tx_byte = dev_addr;
									byte_phase = BYTE_CTRL;
								end
								BYTE_CTRL: begin
									res.tx_byte = held_ctrl;
									byte_phase = BYTE_DATA;
								end
								default: begin
									res.tx_byte = item.payload_byte;
									res.advance_payload = !repeat_mode;
									bytes_left = bytes_left - 16'd1;
								end
							endcase
							bus_phase = BUS_SAMPLE;
						end
					end
					BUS_STOP: begin
						res.action = i2cdws_pkg::ACT_RELEASE;
						res.transfer_done = 1'b1;
						bus_phase = BUS_IDLE;
					end
					default: ;
				endcase
			end
			expected_actions.push_back(res);
			return res.action;
		endfunction

		task report_mismatch(string what);
			if (fail_count < MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, what);
			fail_count++;
		endtask

		// Compares one accepted result with the oldest expected action.
		task check_bus_action(i2cdws_pkg::out_item_t got);
			i2cdws_pkg::out_item_t want;
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = expected_actions.pop_front();
				if (got.action !== want.action)
					report_mismatch($sformatf("action got %0d expected %0d",
						got.action, want.action));
				if (got.tx_byte !== want.tx_byte)
					report_mismatch($sformatf("tx_byte got %h expected %h",
						got.tx_byte, want.tx_byte));
				if (got.advance_payload !== want.advance_payload)
					report_mismatch($sformatf("advance_payload got %b expected %b",
						got.advance_payload, want.advance_payload));
				if (got.request_rejected !== want.request_rejected)
					report_mismatch($sformatf("request_rejected got %b expected %b",
						got.request_rejected, want.request_rejected));
				if (got.transfer_done !== want.transfer_done)
					report_mismatch($sformatf("transfer_done got %b expected %b",
						got.transfer_done, want.transfer_done));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	i2cdws_pkg::in_item_t  req_data = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	i2cdws_pkg::out_item_t rsp_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [7:0]            cfg_data = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int idle_cycles = 0;

	bus_action_scoreboard_t sb;

	i2c_display_write_sequencer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: random stalls, and a check of every accepted result.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_bus_action(rsp_data);
		rsp_stall <= arst_n && ($urandom_range(99) < sink_stall_pct);
	end

	// Watchdog: ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	function automatic i2cdws_pkg::in_item_t random_item(logic cmd);
		i2cdws_pkg::in_item_t item;
		item.cmd = cmd;
		item.ctrl_byte = 8'($urandom_range(255));
		item.data_len = 16'($urandom_range(16'hFFFF));
		item.repeat_payload = 1'($urandom_range(1));
		item.payload_byte = 8'($urandom_range(255));
		item.nack_bit = 1'($urandom_range(1));
		return item;
	endfunction

	// Offers one item, with random idle cycles ahead of it, until it is taken.
	task automatic drive_item(input i2cdws_pkg::in_item_t item,
			output i2cdws_pkg::action_t act);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (req_stall);
		act = sb.note_accepted_item(item);
	endtask

	task automatic drive_fields(logic cmd, logic [7:0] ctrl, logic [15:0] len,
			logic rep, logic [7:0] pay, logic nack);
		i2cdws_pkg::in_item_t item;
		i2cdws_pkg::action_t act;
		item.cmd = cmd;
		item.ctrl_byte = ctrl;
		item.data_len = len;
		item.repeat_payload = rep;
		item.payload_byte = pay;
		item.nack_bit = nack;
		drive_item(item, act);
	endtask

	// Waits until every expected action has come back.
	task automatic drain_actions();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_device_address(logic [7:0] addr);
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_address(addr);
		cfg_valid <= 1'b0;
	endtask

	// Random transfers: mostly well-formed, with stray events, rejected
	// requests and NACKs mixed in. Long transfers are cut short by a NACK.
	task automatic run_random_transfers(int target);
		i2cdws_pkg::in_item_t item;
		i2cdws_pkg::action_t act;
		int counted;
		int steps;
		int pick;
		counted = 0;
		while (counted < target) begin
			if ($urandom_range(9) == 0)
				drive_item(random_item(i2cdws_pkg::CMD_EVENT), act);
			item = random_item(i2cdws_pkg::CMD_REQUEST);
			pick = $urandom_range(99);
			if (pick < 15)
				item.data_len = 16'd0;
			else if (pick < 85)
				item.data_len = 16'($urandom_range(6, 1));
			drive_item(item, act);
			if (act != i2cdws_pkg::ACT_NONE)
				counted++;
			steps = 0;
			while (!sb.is_idle()) begin
				if ($urandom_range(19) == 0) begin
					item = random_item(i2cdws_pkg::CMD_REQUEST);
				end else begin
					item = random_item(i2cdws_pkg::CMD_EVENT);
					item.nack_bit = ($urandom_range(29) == 0) || (steps > 60);
				end
				drive_item(item, act);
				if (act != i2cdws_pkg::ACT_NONE)
					counted++;
				steps++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset address.
		src_idle_pct = 11;
		sink_stall_pct = 72;
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'hFF, 16'd0, 1'b1, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'h12, 16'd3, 1'b0, 8'h34, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'h00, 16'd1, 1'b0, 8'h00, 1'b1);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'hFF, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h5A, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'hA5, 16'hFFFF, 1'b1, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b1);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_REQUEST, 8'h3C, 16'd2, 1'b1, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'hC3, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b1);
		drive_fields(i2cdws_pkg::CMD_EVENT, 8'h00, 16'd0, 1'b0, 8'h00, 1'b0);

		// Random part, lowest address, slow receiver.
		drain_actions();
		write_device_address(8'h00);
		run_random_transfers(ITEMS_PER_PHASE);

		// Highest address, slow sender.
		drain_actions();
		src_idle_pct = 72;
		sink_stall_pct = 11;
		write_device_address(8'hFF);
		run_random_transfers(ITEMS_PER_PHASE);

		// Random address, no idling on either side.
		drain_actions();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_device_address(8'($urandom_range(254, 1)));
		run_random_transfers(ITEMS_PER_PHASE);

		drain_actions();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
